// ===== src/ows_pkg.sv =====
// ----------------------------------------------------------------------------
// ows_pkg: shared types and constants for the rom search core
// Status and operation codes, the result item layout and the crc-8 step.
// ----------------------------------------------------------------------------
package ows_pkg;

  // number of id bits in one rom code
  localparam int ROM_BITS = 64;
  // width of a bit position (0 .. 64)
  localparam int POS_W    = 7;
  // width of a bit offset inside the rom code
  localparam int SH_W     = $clog2(ROM_BITS);
  // width of the rom code field on the port
  localparam int CODE_W   = 64;

  // input operation codes
  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_BEGIN   = 2'd1,
    OP_PAIR    = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_CHOSEN      = 3'd0,
    ST_NO_PRESENCE = 3'd1,
    ST_COMPLETE    = 3'd2,
    ST_NO_DEVICE   = 3'd3,
    ST_FOUND       = 3'd4,
    ST_CRC_ERROR   = 3'd5,
    ST_STARTED     = 3'd6,
    ST_IGNORED     = 3'd7
  } status_t;

  // one result item
  typedef struct packed {
    logic [CODE_W-1:0] rom_code;
    logic              send_alarm_command;
    logic [POS_W-1:0]  bit_index;
    logic              direction;
    status_t           status;
  } result_t;

  // reflected dallas crc-8 update by one bit (x^8+x^5+x^4+1)
  localparam logic [7:0] CRC_POLY = 8'h8C;

  function automatic logic [7:0] crc_bit(input logic [7:0] crc, input logic din);
    logic [7:0] shifted;
    shifted = {1'b0, crc[7:1]};
    if (crc[0] ^ din) begin
      shifted = shifted ^ CRC_POLY;
    end
    return shifted;
  endfunction

endpackage

// ===== src/ows_out_buf.sv =====
// ----------------------------------------------------------------------------
// ows_out_buf: result register with skid stage
// Holds result items for the output channel; a second entry lets the
// core accept a new item while a finished result still waits.
// ----------------------------------------------------------------------------
module ows_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ows_pkg::result_t  push_data,
  output logic              push_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ows_pkg::result_t  out_data
);
  import ows_pkg::*;

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;
  logic    take;

  assign take       = main_valid && out_ready;
  assign push_ready = !skid_valid;
  assign out_valid  = main_valid;
  assign out_data   = main_data;

  // main entry plus overflow entry
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || take) begin
        main_data  <= push_data;
        main_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      main_valid <= 1'b0;
    end
  end

endmodule

// ===== src/onewire_rom_search.sv =====
// ----------------------------------------------------------------------------
// onewire_rom_search: decision core of the 1-wire search rom algorithm
// Picks the direction bit for each id / complement pair, builds the rom
// code and its crc-8, and tracks the search tree across passes.
// ----------------------------------------------------------------------------
// Usage: the input channel (s_axis_*) carries one command per item: the
// operation in tuser, and presence / alarm choice or the two read slot
// values in tdata. Every item yields exactly one result item on the
// output channel (m_axis_*): the status in tuser, and direction, bit
// index, alarm command flag and the current rom code in tdata.
// One item is accepted per cycle while s_axis_tready is high: the search
// state updates in a single pass of logic, and a two-entry result buffer
// (result register plus skid entry) lets an item enter while a result
// waits. When the receiver stalls, up to two results are held and
// s_axis_tready drops until the skid entry drains. Synchronous reset
// clears the search state (bit position to one, everything else to zero)
// and empties the result buffer; a restart operation clears the same
// state in-band.
// ----------------------------------------------------------------------------
module onewire_rom_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] presence_seen, [1] alarm_search, [2] id_bit, [3] complement_bit
  input  logic [7:0]  s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] direction, [7:1] bit_index, [8] send_alarm_command, [72:9] rom_code
  output logic [79:0] m_axis_tdata,
  // [2:0] status
  output logic [2:0]  m_axis_tuser
);
  import ows_pkg::*;

  // search state
  logic [POS_W-1:0]    last_discrepancy;
  logic                last_device;
  logic [ROM_BITS-1:0] rom_bits;
  logic [POS_W-1:0]    bit_position;
  logic [POS_W-1:0]    last_zero_branch;
  logic [7:0]          running_crc;
  logic                pass_active;

  logic [POS_W-1:0]    last_discrepancy_next;
  logic                last_device_next;
  logic [ROM_BITS-1:0] rom_bits_next;
  logic [POS_W-1:0]    bit_position_next;
  logic [POS_W-1:0]    last_zero_branch_next;
  logic [7:0]          running_crc_next;
  logic                pass_active_next;

  logic       accept;
  op_t        op;
  logic       presence;
  logic       alarm;
  logic       idb;
  logic       cmp;
  logic [POS_W-1:0] pos;
  logic [SH_W-1:0]  sh;
  logic       dir;
  logic [7:0] crc_new;
  result_t    res;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign op       = op_t'(s_axis_tuser);
  assign presence = s_axis_tdata[0];
  assign alarm    = s_axis_tdata[1];
  assign idb      = s_axis_tdata[2];
  assign cmp      = s_axis_tdata[3];

  // current position, forced into range, and its bit offset
  always_comb begin
    if (bit_position < POS_W'(1) || bit_position > POS_W'(ROM_BITS)) begin
      pos = POS_W'(1);
    end else begin
      pos = bit_position;
    end
    sh = SH_W'(pos - POS_W'(1));
  end

  // direction choice for a pair and the crc after it
  always_comb begin
    if (!idb && !cmp) begin
      if (pos == last_discrepancy) begin
        dir = 1'b1;
      end else if (pos > last_discrepancy) begin
        dir = 1'b0;
      end else begin
        dir = rom_bits[sh];
      end
    end else begin
      dir = idb;
    end
    crc_new = crc_bit(running_crc, dir);
  end

  // next state and result for one item
  always_comb begin
    last_discrepancy_next = last_discrepancy;
    last_device_next      = last_device;
    rom_bits_next         = rom_bits;
    bit_position_next     = bit_position;
    last_zero_branch_next = last_zero_branch;
    running_crc_next      = running_crc;
    pass_active_next      = pass_active;

    res.status             = ST_IGNORED;
    res.direction          = 1'b0;
    res.bit_index          = '0;
    res.send_alarm_command = 1'b0;

    case (op)
      OP_RESTART: begin
        last_discrepancy_next = '0;
        last_device_next      = 1'b0;
        rom_bits_next         = '0;
        bit_position_next     = POS_W'(1);
        last_zero_branch_next = '0;
        running_crc_next      = '0;
        pass_active_next      = 1'b0;
      end
      OP_BEGIN: begin
        if (!presence) begin
          pass_active_next = 1'b0;
          res.status       = ST_NO_PRESENCE;
        end else if (last_device) begin
          pass_active_next = 1'b0;
          res.status       = ST_COMPLETE;
        end else begin
          pass_active_next       = 1'b1;
          bit_position_next      = POS_W'(1);
          last_zero_branch_next  = '0;
          running_crc_next       = '0;
          res.send_alarm_command = alarm;
          res.status             = ST_STARTED;
        end
      end
      OP_PAIR: begin
        if (pass_active) begin
          if (idb && cmp) begin
            pass_active_next = 1'b0;
            res.status       = ST_NO_DEVICE;
          end else begin
            // zero branch taken at a discrepancy
            if (!idb && !cmp && !dir) begin
              last_zero_branch_next = pos;
            end
            rom_bits_next[sh] = dir;
            running_crc_next  = crc_new;
            res.direction     = dir;
            res.bit_index     = pos;
            if (pos >= POS_W'(ROM_BITS)) begin
              last_discrepancy_next = last_zero_branch_next;
              if (last_zero_branch_next == '0) begin
                last_device_next = 1'b1;
              end
              pass_active_next  = 1'b0;
              bit_position_next = POS_W'(1);
              res.status = (crc_new == 8'd0) ? ST_FOUND : ST_CRC_ERROR;
            end else begin
              bit_position_next = pos + POS_W'(1);
              res.status        = ST_CHOSEN;
            end
          end
        end
      end
      default: begin
        res.status = ST_IGNORED;
      end
    endcase

    res.rom_code = CODE_W'(rom_bits_next);
  end

  // state registers, updated on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      last_discrepancy <= '0;
      last_device      <= 1'b0;
      rom_bits         <= '0;
      bit_position     <= POS_W'(1);
      last_zero_branch <= '0;
      running_crc      <= '0;
      pass_active      <= 1'b0;
    end else if (accept) begin
      last_discrepancy <= last_discrepancy_next;
      last_device      <= last_device_next;
      rom_bits         <= rom_bits_next;
      bit_position     <= bit_position_next;
      last_zero_branch <= last_zero_branch_next;
      running_crc      <= running_crc_next;
      pass_active      <= pass_active_next;
    end
  end

  // result buffer toward the output channel
  result_t out_res;

  ows_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (res),
    .push_ready (s_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (out_res)
  );

  // pack the output item
  assign m_axis_tuser = out_res.status;
  assign m_axis_tdata = {7'd0, out_res.rom_code, out_res.send_alarm_command,
                         out_res.bit_index, out_res.direction};

endmodule
